/* rtl/core/pal_pkg.sv */
`default_nettype none
package pal_pkg;

   localparam int PAL_CAPACITY   = 16;
   localparam int PAL_DATA_WIDTH = 32;
   localparam int PAL_IDX_W      = 11;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOCATE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_BAD_POS   = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic                 ins;
      logic                 cap;
      logic [PAL_IDX_W-1:0] pos;
      logic [PAL_IDX_W-1:0] count;
   } pal_ctl_type;

endpackage
`default_nettype wire

/* rtl/core/positional_array_list_core.sv */
`default_nettype none
// channel  dir  handshake            fields
// req      in   req_valid/req_ready  req_type, req_item_value, req_position
// rsp      out  rsp_valid/rsp_ready  rsp_status, rsp_found_index, rsp_length, rsp_is_empty
// Insert and clear: the result register is loaded directly at the transfer.
// Locate: every cell compares into its match register at the transfer; in ST_FIND the
// match vector is priority encoded (lowest index wins) into the result register.
// Reset clears the count and handshake state only; cell contents are not cleared.
// A waiting result holds the output register; a new request is taken once it is free.
module positional_array_list_core #(
   parameter int CAPACITY   = pal_pkg::PAL_CAPACITY,
   parameter int DATA_WIDTH = pal_pkg::PAL_DATA_WIDTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire        [1:0]  req_type,
   input  wire signed [31:0] req_item_value,
   input  wire        [4:0]  req_position,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic       [1:0]  rsp_status,
   output logic       [3:0]  rsp_found_index,
   output logic       [4:0]  rsp_length,
   output logic              rsp_is_empty
);
   import pal_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FIND = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            status_ff, status_in;
   logic [3:0]            index_ff, index_in;
   logic [4:0]            length_ff, length_in;
   logic                  empty_ff, empty_in;

   logic signed [63:0]    ext;
   logic [DATA_WIDTH-1:0] key;
   logic [PAL_IDX_W-1:0]  pos_w, cnt_w;
   logic                  req_fire, out_free, full, bad_pos;
   pal_ctl_type           ctl;
   logic [DATA_WIDTH-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]   match;
   logic [31:0]           hit_idx, cnt_wide;
   logic                  any_hit;

   assign ext      = 64'(req_item_value);
   assign key      = ext[DATA_WIDTH-1:0];
   assign pos_w    = PAL_IDX_W'(req_position);
   assign cnt_w    = PAL_IDX_W'(count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_valid && req_ready;
   assign full     = 32'(count_ff) >= 32'(CAPACITY);
   assign bad_pos  = pos_w > cnt_w;

   always_comb begin
      ctl.ins   = req_fire && (req_type == OP_INSERT) && !full && !bad_pos;
      ctl.cap   = req_fire && (req_type == OP_LOCATE);
      ctl.pos   = pos_w;
      ctl.count = cnt_w;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      pal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .key      (key),
         .shift_in ((i == 0) ? key : entries[(i == 0) ? 0 : i - 1]),
         .entry    (entries[i]),
         .match    (match[i])
      );
   end

   always_comb begin
      hit_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = 32'(i);
         end
      end
      any_hit = |match;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      index_in     = index_ff;
      if (req_fire) begin
         index_in = '0;
         status_in = STAT_OK;
         case (req_type)
            OP_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else if (bad_pos) begin
                  status_in = STAT_BAD_POS;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         if (req_type == OP_LOCATE) begin
            state_in = ST_FIND;
         end else begin
            rsp_valid_in = 1'b1;
         end
      end else if (state_ff == ST_FIND && out_free) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         status_in    = any_hit ? STAT_OK : STAT_NOT_FOUND;
         index_in     = any_hit ? hit_idx[3:0] : 4'd0;
      end
      cnt_wide  = 32'(count_in);
      length_in = cnt_wide[4:0];
      empty_in  = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      index_ff  <= index_in;
      length_ff <= length_in;
      empty_ff  <= empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_index = index_ff;
   assign rsp_length      = length_ff;
   assign rsp_is_empty    = empty_ff;

endmodule
`default_nettype wire

/* rtl/core/pal_cell.sv */
`default_nettype none
module pal_cell #(
   parameter int DATA_WIDTH = pal_pkg::PAL_DATA_WIDTH,
   parameter int INDEX      = 0
) (
   input  wire                      clock,
   input  pal_pkg::pal_ctl_type     ctl,
   input  wire     [DATA_WIDTH-1:0] key,
   input  wire     [DATA_WIDTH-1:0] shift_in,
   output logic    [DATA_WIDTH-1:0] entry,
   output logic                     match
);
   import pal_pkg::*;

   localparam logic [PAL_IDX_W-1:0] IDX = PAL_IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic                  match_ff;

   always_ff @(posedge clock) begin
      if (ctl.ins) begin
         if (IDX == ctl.pos) begin
            entry_ff <= key;
         end else if (IDX > ctl.pos && IDX <= ctl.count) begin
            entry_ff <= shift_in;
         end
      end
      if (ctl.cap) begin
         match_ff <= (entry_ff == key) && (IDX < ctl.count);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule
`default_nettype wire
